// ===== hw/rtl/u8u16_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

	// Field widths
	localparam int BYTE_W  = 8;
	localparam int UNIT_W  = 16;
	localparam int LEFT_W  = 3;
	localparam int ACC_W   = 31;
	localparam int CONT_W  = 6;
	localparam int HALF_W  = 10;

	// Result queue geometry
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Longest sequence leaves this many continuation bytes to come
	localparam logic [LEFT_W-1:0] MAX_LEFT = 3'd5;

	// Surrogate construction
	localparam logic [HALF_W-1:0] PLANE1_HI = 10'h040;
	localparam logic [5:0]        HI_SURR   = 6'b110110;
	localparam logic [5:0]        LO_SURR   = 6'b110111;
	localparam logic [4:0]        SURR_TOP  = 5'b11011;

	// Lead bytes that open no sequence
	localparam logic [BYTE_W-1:0] FIRST_BAD_LEAD = 8'hFE;

	// One result beat
	typedef struct packed {
		logic              bad;
		logic              last;
		logic [UNIT_W-1:0] unit;
	} unit_t;

endpackage

// ===== hw/rtl/utf8_to_utf16_transcoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder
// Decodes a UTF-8 byte stream (1 to 6 byte sequences, 31-bit form) into
// UTF-16 code units, splitting values outside the basic plane into
// surrogate pairs.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  tdata            tlast       tuser
//  s_axis    in   byte_in[7:0]     -           -
//  m_axis    out  code_unit[15:0]  last_unit   bad_lead
//
//  One byte is taken per cycle while s_axis_tready is high; its units are decoded
//  in the same cycle and written into a 4-entry result queue, so they appear on
//  m_axis in the next cycle at the earliest.
//  A byte that ends a character needing a surrogate pair (above 0xFFFF or a
//  surrogate value) yields two beats; the output side drains one beat per
//  cycle while m_axis_tready is high, which bounds sustained throughput.
//  s_axis_tready is high while the queue has room for two beats.
//  arst_n clears the sequence state and empties the queue.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [15:0] code_unit
	output logic        m_axis_tlast,
	output logic        m_axis_tuser    // [0] bad_lead
);

	localparam int BYTE_W = u8u16_pkg::BYTE_W;
	localparam int UNIT_W = u8u16_pkg::UNIT_W;
	localparam int LEFT_W = u8u16_pkg::LEFT_W;
	localparam int ACC_W  = u8u16_pkg::ACC_W;
	localparam int CONT_W = u8u16_pkg::CONT_W;
	localparam int HALF_W = u8u16_pkg::HALF_W;
	localparam int DEPTH  = u8u16_pkg::QUEUE_DEPTH;
	localparam int PTR_W  = u8u16_pkg::QPTR_W;
	localparam int CNT_W  = u8u16_pkg::QCNT_W;

	// Sequence state
	logic [LEFT_W-1:0] left_q;
	logic [ACC_W-1:0]  acc_q;
	logic [LEFT_W-1:0] left_nx;
	logic [ACC_W-1:0]  acc_nx;

	// Result queue
	u8u16_pkg::unit_t  queue_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	logic              in_fire;
	logic              out_fire;
	logic [1:0]        n_push;
	u8u16_pkg::unit_t  res0;
	u8u16_pkg::unit_t  res1;

	logic [BYTE_W-1:0] b;
	logic [ACC_W-1:0]  cp;
	logic              cp_single;
	logic [HALF_W-1:0] hi_bits;
	logic [LEFT_W-1:0] left_dec;

	assign b        = s_axis_tdata;
	assign in_fire  = s_axis_tvalid && s_axis_tready;
	assign out_fire = m_axis_tvalid && m_axis_tready;

	// Accept while two free slots remain
	assign s_axis_tready = (count_q <= CNT_W'(DEPTH - 2));

	// Continuation: shift the low six bits into the accumulator
	assign cp        = {acc_q[ACC_W-CONT_W-1:0], b[CONT_W-1:0]};
	assign cp_single = (cp[ACC_W-1:UNIT_W] == '0) && (cp[15:11] != u8u16_pkg::SURR_TOP);
	assign hi_bits   = cp[2*HALF_W-1:HALF_W] - u8u16_pkg::PLANE1_HI;

	// Decode a lead byte into the count of bytes still to come
	always_comb begin
		priority if (!b[5]) begin
			left_dec = 3'd1;
		end else if (!b[4]) begin
			left_dec = 3'd2;
		end else if (!b[3]) begin
			left_dec = 3'd3;
		end else if (!b[2]) begin
			left_dec = 3'd4;
		end else begin
			left_dec = u8u16_pkg::MAX_LEFT;
		end
	end

	// Decode one byte into state update and up to two result beats
	always_comb begin
		left_nx = left_q;
		acc_nx  = acc_q;
		n_push  = 2'd0;
		res0    = '{bad: 1'b0, last: 1'b1, unit: '0};
		res1    = '{bad: 1'b0, last: 1'b1, unit: {u8u16_pkg::LO_SURR, cp[HALF_W-1:0]}};
		if (left_q != '0) begin
			acc_nx  = cp;
			left_nx = left_q - LEFT_W'(1);
			if (left_q == LEFT_W'(1)) begin
				if (cp_single) begin
					n_push    = 2'd1;
					res0.unit = cp[UNIT_W-1:0];
				end else begin
					n_push    = 2'd2;
					res0.last = 1'b0;
					res0.unit = {u8u16_pkg::HI_SURR, hi_bits};
				end
			end
		end else if (!b[7]) begin
			n_push    = 2'd1;
			res0.unit = UNIT_W'(b);
		end else if (!b[6] || b >= u8u16_pkg::FIRST_BAD_LEAD) begin
			n_push   = 2'd1;
			res0.bad = 1'b1;
		end else begin
			left_nx = left_dec;
			// Keep the payload bits below the length marker
			acc_nx  = ACC_W'(b[5:0] & (6'h3F >> left_dec));
		end
	end

	// Hold sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			acc_q  <= '0;
		end else if (in_fire) begin
			left_q <= left_nx;
			acc_q  <= acc_nx;
		end
	end

	// Write result beats into the queue
	always_ff @(posedge clk) begin
		if (in_fire && n_push != 2'd0) begin
			queue_q[wr_ptr_q] <= res0;
		end
		if (in_fire && n_push == 2'd2) begin
			queue_q[wr_ptr_q + PTR_W'(1)] <= res1;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (in_fire) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(n_push);
			end
			if (out_fire) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + (in_fire ? CNT_W'(n_push) : '0) - CNT_W'(out_fire);
		end
	end

	// Present the head beat
	assign m_axis_tvalid = (count_q != '0);
	assign m_axis_tdata  = queue_q[rd_ptr_q].unit;
	assign m_axis_tlast  = queue_q[rd_ptr_q].last;
	assign m_axis_tuser  = queue_q[rd_ptr_q].bad;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("result queue overflow");

	a_left_bound: assert property (@(posedge clk) disable iff (!arst_n)
		left_q <= u8u16_pkg::MAX_LEFT)
		else $error("sequence length out of range");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0 && m_axis_tlast)
		else $error("bad lead beat must be a zero final unit");

	a_ascii_push: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && left_q == '0 && !s_axis_tdata[7] && !out_fire
		|=> count_q == $past(count_q) + CNT_W'(1))
		else $error("ASCII byte did not queue one beat");

	a_hi_half: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[15:10] == u8u16_pkg::HI_SURR
		&& count_q >= CNT_W'(2))
		else $error("first half without its partner queued");
`endif

endmodule
